### hdl/chm_pkg.sv
// Calorimeter hit merger: shared types, codes and the attenuation table.
// No dependencies; used by the top level.
package chm_pkg;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [3:0]         block_row;
    logic [3:0]         block_column;
    logic signed [11:0] depth_z;
    logic [19:0]        step_time;
    logic [19:0]        energy_deposit;
    logic [3:0]         read_index;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  hit_slot;
    logic [20:0] hit_time;
    logic [23:0] hit_energy;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CNT, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_MUL5,
    ST_SCAN_RD, ST_SCAN_CMP, ST_MEAN1, ST_MEAN2, ST_MEAN3, ST_DIV, ST_WRITE
  } state_t;

  localparam logic [1:0] CMD_DEPOSIT = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam logic [2:0] STAT_MERGED  = 3'd0;
  localparam logic [2:0] STAT_NEW     = 3'd1;
  localparam logic [2:0] STAT_DROPPED = 3'd2;
  localparam logic [2:0] STAT_READ_OK = 3'd3;
  localparam logic [2:0] STAT_NONE    = 3'd4;
  localparam logic [2:0] STAT_CLEARED = 3'd5;
  localparam logic [2:0] STAT_NO_DEP  = 3'd6;

  localparam logic [2:0] REG_HALF_LENGTH  = 3'd0;
  localparam logic [2:0] REG_ATTEN_COEFF  = 3'd1;
  localparam logic [2:0] REG_TIME_PER_DST = 3'd2;
  localparam logic [2:0] REG_MERGE_WINDOW = 3'd3;
  localparam logic [2:0] REG_MAX_HITS     = 3'd4;
  localparam logic [2:0] REG_E_THRESHOLD  = 3'd5;

  localparam logic [23:0] E_MAX = 24'hFFFFFF;

  // 2^-(i/16) in Q16, i = 0..16
  function automatic logic [16:0] exp2_tab(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44377;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

### hdl/chm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### hdl/calorimeter_hit_merger_unit.sv
// Calorimeter hit merger, top level.
// Depends on chm_pkg and chm_ram.
//
// Command port: an item is taken when start is high and busy is low. Each item
// gives one result beat on result, marked by done for one cycle; the receiver
// cannot hold it off. A new item may be started in the cycle done is high.
// Configuration: cfg_we writes cfg_data to register cfg_index at once; the user must
// write only while the block is idle, which the block itself does not enforce.
// Sequencing, from the accepting edge to the done beat:
//   unused command, zero deposit, read of a block off the grid: answered from idle
//   clear: one hit-count entry zeroed a cycle, over all ROWS*COLUMNS entries
//   read: per slot examined, a RAM read state and then a compare state, until a hit
//   is found or the list ends
//   deposit: the attenuation and time multiplies, then the same slot scan; a merge
//   adds the weighted mean time, mostly the 21-step restoring divider.
// Reset: registers go to their defaults, then the hit-count store is cleared
// one entry a cycle with busy high; no result beat is given for it.
module calorimeter_hit_merger_unit #(
  parameter int ROWS           = 16,
  parameter int COLUMNS        = 16,
  parameter int HITS_PER_BLOCK = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  chm_pkg::item_t   item,
  output logic            done,
  output chm_pkg::result_t result,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [23:0]     cfg_data
);
  localparam int NBLK   = ROWS * COLUMNS;
  localparam int NSLOT  = NBLK * HITS_PER_BLOCK;
  localparam int BLK_W  = NBLK > 1 ? $clog2(NBLK) : 1;
  localparam int ADDR_W = NSLOT > 1 ? $clog2(NSLOT) : 1;
  localparam int CNT_W  = $clog2(HITS_PER_BLOCK + 1);

  // configuration
  logic [11:0] half_length;
  logic [15:0] atten_coeff, time_per_distance, merge_window;
  logic [4:0]  max_hits_in_use;
  logic [23:0] energy_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_length       <= 12'd640;
      atten_coeff       <= 16'd1891;
      time_per_distance <= 16'd1260;
      merge_window      <= 16'd1200;
      max_hits_in_use   <= 5'd16;
      energy_threshold  <= 24'd5000;
    end else if (cfg_we) begin
      case (cfg_index)
        chm_pkg::REG_HALF_LENGTH:  half_length       <= cfg_data[11:0];
        chm_pkg::REG_ATTEN_COEFF:  atten_coeff       <= cfg_data[15:0];
        chm_pkg::REG_TIME_PER_DST: time_per_distance <= cfg_data[15:0];
        chm_pkg::REG_MERGE_WINDOW: merge_window      <= cfg_data[15:0];
        chm_pkg::REG_MAX_HITS:     max_hits_in_use   <= cfg_data[4:0];
        chm_pkg::REG_E_THRESHOLD:  energy_threshold  <= cfg_data;
        default: ;
      endcase
    end
  end

  chm_pkg::state_t state, state_next;

  logic [1:0]       cmd_r;
  logic [BLK_W-1:0] blk_r, clr_idx;
  logic             inside_r, clr_emit;
  logic [19:0]      stime_r, edep_r;
  logic [3:0]       ridx_r;
  logic [12:0]      distance;
  logic [28:0]      xprod, dprod;
  logic [27:0]      iprod;
  logic [16:0]      fac;
  logic [36:0]      eprod;
  logic [20:0]      tc, hit_t, qsh;
  logic [19:0]      ec;
  logic [23:0]      hit_e;
  logic [CNT_W-1:0] cnt_r, slot;
  logic [4:0]       seen, div_cnt;
  logic [44:0]      p1, p2;
  logic [24:0]      den, rem;

  // item decode
  logic             accept, item_inside;
  logic [BLK_W-1:0] item_blk;
  logic [13:0]      sd;
  assign accept      = start && !busy;
  assign item_inside = int'(item.block_row) < ROWS && int'(item.block_column) < COLUMNS;
  assign item_blk    = item_inside
      ? BLK_W'(int'(item.block_row) * COLUMNS + int'(item.block_column)) : '0;
  assign sd          = $signed({2'b00, half_length}) - $signed({{2{item.depth_z[11]}}, item.depth_z});

  // memories
  logic             cnt_we, dat_we, dat_re;
  logic [BLK_W-1:0] cnt_waddr;
  logic [CNT_W-1:0] cnt_wdata, cnt_rdata;
  logic [ADDR_W-1:0] dat_addr;
  logic [44:0]      dat_wdata, dat_rdata;

  assign dat_addr = ADDR_W'(ADDR_W'(blk_r) * ADDR_W'(HITS_PER_BLOCK)) + ADDR_W'(slot);

  chm_ram #(.WIDTH(CNT_W), .DEPTH(NBLK)) u_count_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .re(accept), .raddr(item_blk), .rdata(cnt_rdata)
  );

  chm_ram #(.WIDTH(45), .DEPTH(NSLOT)) u_hit_ram (
    .clk(clk), .we(dat_we), .waddr(dat_addr), .wdata(dat_wdata),
    .re(dat_re), .raddr(dat_addr), .rdata(dat_rdata)
  );

  // derived values
  logic [20:0] rd_t, diff;
  logic [23:0] rd_e, sat_e;
  logic [3:0]  tab_idx;
  logic [16:0] tab_a, tab_b;
  logic        full, above;
  logic [45:0] num;
  logic [25:0] rem_sh;
  logic        ge;
  logic [5:0]  shamt;

  assign rd_t    = dat_rdata[44:24];
  assign rd_e    = dat_rdata[23:0];
  assign diff    = rd_t > tc ? rd_t - tc : tc - rd_t;
  assign above   = rd_e > energy_threshold;
  assign tab_idx = xprod[23:20];
  assign tab_a   = chm_pkg::exp2_tab({1'b0, tab_idx});
  assign tab_b   = chm_pkg::exp2_tab(5'({1'b0, tab_idx} + 5'd1));
  assign full    = {3'b000, cnt_r} >= 8'(max_hits_in_use) ||
                   int'(cnt_r) >= HITS_PER_BLOCK;
  assign sat_e   = den > {1'b0, chm_pkg::E_MAX} ? chm_pkg::E_MAX : den[23:0];
  assign num     = {1'b0, p1} + {1'b0, p2};
  assign rem_sh  = {rem, qsh[20]};
  assign ge      = rem_sh >= {1'b0, den};
  assign shamt   = 6'd16 + {1'b0, xprod[28:24]};

  // control
  logic             emit;
  chm_pkg::result_t emit_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chm_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_res   = '0;
    cnt_we     = 1'b0;
    cnt_waddr  = blk_r;
    cnt_wdata  = CNT_W'(cnt_r + 1'b1);
    dat_we     = 1'b0;
    dat_re     = 1'b0;
    dat_wdata  = {tc, 4'd0, ec};
    case (state)
      chm_pkg::ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_idx;
        cnt_wdata = '0;
        if (int'(clr_idx) == NBLK - 1) begin
          state_next      = chm_pkg::ST_IDLE;
          emit            = clr_emit;
          emit_res.status = chm_pkg::STAT_CLEARED;
        end
      end
      chm_pkg::ST_IDLE: begin
        if (accept) begin
          case (item.cmd)
            chm_pkg::CMD_CLEAR: state_next = chm_pkg::ST_CLEAR;
            chm_pkg::CMD_READ: begin
              if (item_inside) begin
                state_next = chm_pkg::ST_CNT;
              end else begin
                emit            = 1'b1;
                emit_res.status = chm_pkg::STAT_NONE;
              end
            end
            chm_pkg::CMD_DEPOSIT: begin
              if (item.energy_deposit != '0) begin
                state_next = chm_pkg::ST_CNT;
              end else begin
                emit            = 1'b1;
                emit_res.status = chm_pkg::STAT_NO_DEP;
              end
            end
            default: begin
              emit            = 1'b1;
              emit_res.status = chm_pkg::STAT_NO_DEP;
            end
          endcase
        end
      end
      chm_pkg::ST_CNT: begin
        state_next = cmd_r == chm_pkg::CMD_READ ? chm_pkg::ST_SCAN_RD : chm_pkg::ST_MUL1;
      end
      chm_pkg::ST_MUL1: state_next = chm_pkg::ST_MUL2;
      chm_pkg::ST_MUL2: state_next = chm_pkg::ST_MUL3;
      chm_pkg::ST_MUL3: state_next = chm_pkg::ST_MUL4;
      chm_pkg::ST_MUL4: state_next = chm_pkg::ST_MUL5;
      chm_pkg::ST_MUL5: state_next = chm_pkg::ST_SCAN_RD;
      chm_pkg::ST_SCAN_RD: begin
        if (cmd_r == chm_pkg::CMD_DEPOSIT && !inside_r) begin
          state_next          = chm_pkg::ST_IDLE;
          emit                = 1'b1;
          emit_res.status     = chm_pkg::STAT_DROPPED;
          emit_res.hit_time   = tc;
          emit_res.hit_energy = {4'd0, ec};
        end else if (slot < cnt_r) begin
          dat_re     = 1'b1;
          state_next = chm_pkg::ST_SCAN_CMP;
        end else begin
          state_next = chm_pkg::ST_IDLE;
          emit       = 1'b1;
          if (cmd_r == chm_pkg::CMD_READ) begin
            emit_res.status = chm_pkg::STAT_NONE;
          end else begin
            emit_res.hit_time   = tc;
            emit_res.hit_energy = {4'd0, ec};
            if (full) begin
              emit_res.status = chm_pkg::STAT_DROPPED;
            end else begin
              // append: slot equals the count here
              dat_we            = 1'b1;
              cnt_we            = 1'b1;
              emit_res.status   = chm_pkg::STAT_NEW;
              emit_res.hit_slot = 4'(slot);
            end
          end
        end
      end
      chm_pkg::ST_SCAN_CMP: begin
        state_next = chm_pkg::ST_SCAN_RD;
        if (cmd_r == chm_pkg::CMD_READ) begin
          if (above && seen == {1'b0, ridx_r}) begin
            state_next          = chm_pkg::ST_IDLE;
            emit                = 1'b1;
            emit_res.status     = chm_pkg::STAT_READ_OK;
            emit_res.hit_slot   = 4'(slot);
            emit_res.hit_time   = rd_t;
            emit_res.hit_energy = rd_e;
          end
        end else if (diff < {5'd0, merge_window}) begin
          state_next = chm_pkg::ST_MEAN1;
        end
      end
      chm_pkg::ST_MEAN1: state_next = chm_pkg::ST_MEAN2;
      chm_pkg::ST_MEAN2: state_next = chm_pkg::ST_MEAN3;
      chm_pkg::ST_MEAN3: begin
        state_next = den == '0 ? chm_pkg::ST_WRITE : chm_pkg::ST_DIV;
      end
      chm_pkg::ST_DIV: begin
        if (div_cnt == 5'd20) begin
          state_next = chm_pkg::ST_WRITE;
        end
      end
      chm_pkg::ST_WRITE: begin
        state_next          = chm_pkg::ST_IDLE;
        dat_we              = 1'b1;
        dat_wdata           = {qsh, sat_e};
        emit                = 1'b1;
        emit_res.status     = chm_pkg::STAT_MERGED;
        emit_res.hit_slot   = 4'(slot);
        emit_res.hit_time   = qsh;
        emit_res.hit_energy = sat_e;
      end
      default: state_next = chm_pkg::ST_IDLE;
    endcase
  end

  assign busy = state != chm_pkg::ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      clr_idx  <= '0;
      clr_emit <= 1'b0;
    end else begin
      done <= emit;
      if (emit) begin
        result <= emit_res;
      end
      if (state == chm_pkg::ST_CLEAR) begin
        clr_idx <= BLK_W'(clr_idx + 1'b1);
      end else begin
        clr_idx  <= '0;
        clr_emit <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      chm_pkg::ST_IDLE: begin
        cmd_r    <= item.cmd;
        blk_r    <= item_blk;
        inside_r <= item_inside;
        stime_r  <= item.step_time;
        edep_r   <= item.energy_deposit;
        ridx_r   <= item.read_index;
        distance <= sd[13] ? '0 : sd[12:0];
        slot     <= '0;
        seen     <= '0;
      end
      chm_pkg::ST_CNT:  cnt_r <= cnt_rdata;
      chm_pkg::ST_MUL1: xprod <= distance * atten_coeff;
      chm_pkg::ST_MUL2: begin
        iprod <= 28'(tab_a - tab_b) * xprod[19:4];
        dprod <= distance * time_per_distance;
      end
      chm_pkg::ST_MUL3: begin
        fac <= tab_a - 17'(iprod[27:16]);
        tc  <= 21'(stime_r) + 21'(dprod[28:16]);
      end
      chm_pkg::ST_MUL4: eprod <= edep_r * fac;
      chm_pkg::ST_MUL5: ec    <= 20'(eprod >> shamt);
      chm_pkg::ST_SCAN_CMP: begin
        hit_t <= rd_t;
        hit_e <= rd_e;
        if (cmd_r == chm_pkg::CMD_READ) begin
          slot <= CNT_W'(slot + 1'b1);
          if (above) begin
            seen <= seen + 5'd1;
          end
        end else if (!(diff < {5'd0, merge_window})) begin
          slot <= CNT_W'(slot + 1'b1);
        end
      end
      chm_pkg::ST_MEAN1: begin
        p1  <= hit_t * hit_e;
        den <= {1'b0, hit_e} + 25'(ec);
      end
      chm_pkg::ST_MEAN2: p2 <= tc * {4'd0, ec};
      chm_pkg::ST_MEAN3: begin
        div_cnt <= '0;
        if (den == '0) begin
          qsh <= hit_t;
        end else begin
          rem <= num[45:21];
          qsh <= num[20:0];
        end
      end
      chm_pkg::ST_DIV: begin
        div_cnt <= div_cnt + 5'd1;
        rem     <= ge ? 25'(rem_sh - {1'b0, den}) : rem_sh[24:0];
        qsh     <= {qsh[19:0], ge};
      end
      default: ;
    endcase
  end

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == chm_pkg::ST_IDLE)
    else $error("result beat while the sequencer is still working");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) && !rst |-> busy)
    else $error("hit-count clearing pass skipped after reset");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_we |-> int'(cnt_wdata) <= HITS_PER_BLOCK)
    else $error("hit count written beyond list size");

  a_div_den: assert property (@(posedge clk) disable iff (rst)
    state == chm_pkg::ST_DIV |-> den != '0)
    else $error("divider running on a zero energy sum");

endmodule
